// ===== src/uart_rb_pkg.sv =====
// Shared types and constants for the serial-port ring buffer engine.
package uart_rb_pkg;

  localparam int RX_DEPTH_DEF = 256;
  localparam int TX_DEPTH_DEF = 256;
  localparam int BURST_DEF    = 16;
  localparam int READ_MAX     = 16;
  localparam int CNT_W        = 5;

  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_BS  = 8'h08;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RECV  = 2'd1,
    OP_TXE   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_WACK = 3'd0,
    KIND_RXST = 3'd1,
    KIND_LINE = 3'd2,
    KIND_READ = 3'd3,
    KIND_IDLE = 3'd4
  } kind_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [7:0]       tx_byte;
    logic             crlf;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_LF,
    ST_RESP,
    ST_TX_RD,
    ST_TX_OUT,
    ST_RX_RD,
    ST_RX_OUT
  } state_t;

endpackage

// ===== src/uart_rb_if.sv =====
// Request and result channel interfaces of the serial-port ring buffer engine.
interface uart_rb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data;
  logic [4:0] count;

  modport source (output valid, output operation, output data, output count, input ready);
  modport sink (input valid, input operation, input data, input count, output ready);
endinterface

interface uart_rb_out_if #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uart_rb_pkg::TX_DEPTH_DEF
);
  localparam int RX_LW = $clog2(RX_DEPTH + 1);
  localparam int TX_LW = $clog2(TX_DEPTH + 1);

  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       byte_out;
  logic             ok;
  logic             last;
  logic             tx_irq_enable;
  logic [RX_LW-1:0] rx_level;
  logic [TX_LW-1:0] tx_level;

  modport source (output valid, output kind, output byte_out, output ok, output last,
                  output tx_irq_enable, output rx_level, output tx_level, input ready);
  modport sink (input valid, input kind, input byte_out, input ok, input last,
                input tx_irq_enable, input rx_level, input tx_level, output ready);
endinterface

// ===== src/uart_rb_front.sv =====
// Front end: classifies incoming transactions and holds them in a two-entry command queue.
module uart_rb_front (
  input  logic              clk,
  input  logic              rst,
  uart_rb_in_if.sink        req,
  output uart_rb_pkg::cmd_t cmd,
  output logic              cmd_valid,
  input  logic              cmd_pop
);
  import uart_rb_pkg::*;

  cmd_t       q [2];
  cmd_t       cls;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       push;
  logic [7:0] echo_byte;

  // The echo mapping is worked out here so that the engine only has to store bytes.
  always_comb begin
    echo_byte = req.data;
    if (req.data == BYTE_CR) begin
      echo_byte = BYTE_LF;
    end else if (req.data == BYTE_DEL) begin
      echo_byte = BYTE_BS;
    end
    cls.op      = op_t'(req.operation);
    cls.data    = req.data;
    cls.tx_byte = (cls.op == OP_RECV) ? echo_byte : req.data;
    cls.crlf    = (cls.tx_byte == BYTE_LF);
    cls.count   = (req.count > CNT_W'(READ_MAX)) ? CNT_W'(READ_MAX) : req.count;
  end

  assign req.ready = (used != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (used != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= used + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== src/uart_rb_back.sv =====
// Back end: executes commands against the transmit and receive rings and drives results.
module uart_rb_back #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uart_rb_pkg::TX_DEPTH_DEF,
  parameter int BURST    = uart_rb_pkg::BURST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  uart_rb_pkg::cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  uart_rb_out_if.source     rsp
);
  import uart_rb_pkg::*;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_LW = $clog2(RX_DEPTH + 1);
  localparam int TX_LW = $clog2(TX_DEPTH + 1);
  localparam int BW    = $clog2(BURST + 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;

  state_t           state, state_next;
  cmd_t             cur, cur_next;
  logic             echo_en;
  logic [RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [RX_LW-1:0] rx_fill, rx_fill_next;
  logic [TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [TX_LW-1:0] tx_fill, tx_fill_next;
  logic             tx_irq, tx_irq_next;
  logic [BW-1:0]    burst_n, burst_n_next;
  logic [CNT_W-1:0] read_n, read_n_next;
  kind_t            resp_kind, resp_kind_next;
  logic [7:0]       resp_byte, resp_byte_next;
  logic             resp_ok, resp_ok_next;

  logic             rx_we, tx_we, rx_re, tx_re;
  logic [7:0]       tx_wdata;
  logic             rx_room, tx_room;
  logic [RX_AW-1:0] rx_tail_inc, rx_head_inc;
  logic [TX_AW-1:0] tx_tail_inc, tx_head_inc;

  logic             out_free, out_load;
  kind_t            out_kind;
  logic [7:0]       out_byte;
  logic             out_ok, out_last;

  logic             o_valid;
  kind_t            o_kind;
  logic [7:0]       o_byte;
  logic             o_ok, o_last, o_irq;
  logic [RX_LW-1:0] o_rx_level;
  logic [TX_LW-1:0] o_tx_level;

  assign rx_room     = rx_fill < RX_LW'(RX_DEPTH);
  assign tx_room     = tx_fill < TX_LW'(TX_DEPTH - 1);
  assign rx_tail_inc = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;
  assign rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
  assign tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
  assign out_free    = !o_valid || rsp.ready;

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    rx_fill_next   = rx_fill;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    tx_fill_next   = tx_fill;
    tx_irq_next    = tx_irq;
    burst_n_next   = burst_n;
    read_n_next    = read_n;
    resp_kind_next = resp_kind;
    resp_byte_next = resp_byte;
    resp_ok_next   = resp_ok;
    cmd_pop        = 1'b0;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_re          = 1'b0;
    tx_wdata       = cmd.crlf ? BYTE_CR : cmd.tx_byte;
    out_load       = 1'b0;
    out_kind       = resp_kind;
    out_byte       = resp_byte;
    out_ok         = resp_ok;
    out_last       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cur_next       = cmd;
          resp_byte_next = cmd.data;
          state_next     = ST_RESP;
          unique case (cmd.op)
            OP_WRITE: begin
              resp_kind_next = KIND_WACK;
              resp_ok_next   = tx_room;
              tx_irq_next    = 1'b1;
              if (tx_room) begin
                tx_we        = 1'b1;
                tx_tail_next = tx_tail_inc;
                tx_fill_next = tx_fill + 1'b1;
                if (cmd.crlf) begin
                  state_next = ST_PUSH_LF;
                end
              end
            end
            OP_RECV: begin
              resp_kind_next = KIND_RXST;
              resp_ok_next   = rx_room;
              if (rx_room) begin
                rx_we        = 1'b1;
                rx_tail_next = rx_tail_inc;
                rx_fill_next = rx_fill + 1'b1;
                if (echo_en) begin
                  tx_irq_next = 1'b1;
                  if (tx_room) begin
                    tx_we        = 1'b1;
                    tx_tail_next = tx_tail_inc;
                    tx_fill_next = tx_fill + 1'b1;
                    if (cmd.crlf) begin
                      state_next = ST_PUSH_LF;
                    end
                  end
                end
              end
            end
            OP_TXE: begin
              if (tx_fill == '0) begin
                tx_irq_next    = 1'b0;
                resp_kind_next = KIND_IDLE;
                resp_byte_next = 8'h00;
                resp_ok_next   = 1'b0;
              end else begin
                burst_n_next = '0;
                state_next   = ST_TX_RD;
              end
            end
            OP_READ: begin
              if (cmd.count == '0 || rx_fill == '0) begin
                resp_kind_next = KIND_READ;
                resp_byte_next = 8'h00;
                resp_ok_next   = 1'b0;
              end else begin
                read_n_next = '0;
                state_next  = ST_RX_RD;
              end
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_PUSH_LF: begin
        tx_we        = 1'b1;
        tx_wdata     = BYTE_LF;
        tx_tail_next = tx_tail_inc;
        tx_fill_next = tx_fill + 1'b1;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TX_RD: begin
        tx_re        = 1'b1;
        tx_head_next = tx_head_inc;
        tx_fill_next = tx_fill - 1'b1;
        burst_n_next = burst_n + 1'b1;
        state_next   = ST_TX_OUT;
      end
      ST_TX_OUT: begin
        out_kind = KIND_LINE;
        out_byte = tx_rdata;
        out_ok   = 1'b1;
        out_last = (burst_n == BW'(BURST)) || (tx_fill == '0);
        if (out_free) begin
          out_load   = 1'b1;
          state_next = out_last ? ST_IDLE : ST_TX_RD;
        end
      end
      ST_RX_RD: begin
        rx_re        = 1'b1;
        rx_head_next = rx_head_inc;
        rx_fill_next = rx_fill - 1'b1;
        read_n_next  = read_n + 1'b1;
        state_next   = ST_RX_OUT;
      end
      ST_RX_OUT: begin
        out_kind = KIND_READ;
        out_byte = rx_rdata;
        out_ok   = 1'b1;
        out_last = (read_n == cur.count) || (rx_fill == '0);
        if (out_free) begin
          out_load   = 1'b1;
          state_next = out_last ? ST_IDLE : ST_RX_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_tail] <= cmd.data;
    end
    if (rx_re) begin
      rx_rdata <= rx_mem[rx_head];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_tail] <= tx_wdata;
    end
    if (tx_re) begin
      tx_rdata <= tx_mem[tx_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      echo_en <= 1'b0;
      rx_head <= '0;
      rx_tail <= '0;
      rx_fill <= '0;
      tx_head <= '0;
      tx_tail <= '0;
      tx_fill <= '0;
      tx_irq  <= 1'b0;
      burst_n <= '0;
      read_n  <= '0;
    end else begin
      state   <= state_next;
      rx_head <= rx_head_next;
      rx_tail <= rx_tail_next;
      rx_fill <= rx_fill_next;
      tx_head <= tx_head_next;
      tx_tail <= tx_tail_next;
      tx_fill <= tx_fill_next;
      tx_irq  <= tx_irq_next;
      burst_n <= burst_n_next;
      read_n  <= read_n_next;
      if (cfg_we) begin
        echo_en <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    resp_kind <= resp_kind_next;
    resp_byte <= resp_byte_next;
    resp_ok   <= resp_ok_next;
  end

  // The levels and interrupt enable are already up to date when a result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind     <= out_kind;
      o_byte     <= out_byte;
      o_ok       <= out_ok;
      o_last     <= out_last;
      o_irq      <= tx_irq;
      o_rx_level <= rx_fill;
      o_tx_level <= tx_fill;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.kind          = o_kind;
  assign rsp.byte_out      = o_byte;
  assign rsp.ok            = o_ok;
  assign rsp.last          = o_last;
  assign rsp.tx_irq_enable = o_irq;
  assign rsp.rx_level      = o_rx_level;
  assign rsp.tx_level      = o_tx_level;

endmodule

// ===== src/uart_ring_buffers_crlf.sv =====
// Top level of the serial-port ring buffer engine.
// The engine keeps a transmit ring and a receive ring and answers host writes, received line
// bytes, transmitter-empty events and host reads with one or more result transactions, the
// last of which is marked. A two-entry command queue takes requests while the engine works.
// A host write or received byte passes through the engine states IDLE and RESP, with PUSH_LF
// between them when a line feed is stored as a CR LF pair. Each byte sent to the line or
// returned to the host passes through the registered read of the ring memory and then the
// output register, and the next byte is read only once the output register has taken it.
// The echo enable may be written only while no transaction is outstanding.
module uart_ring_buffers_crlf #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uart_rb_pkg::TX_DEPTH_DEF,
  parameter int BURST    = uart_rb_pkg::BURST_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           cfg_we,
  input logic           cfg_wdata,
  uart_rb_in_if.sink    req,
  uart_rb_out_if.source rsp
);

  uart_rb_pkg::cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_pop;

  uart_rb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  uart_rb_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH),
    .BURST    (BURST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

// ===== src/uart_rb_checker.sv =====
// Port-level assertions for the serial-port ring buffer engine, bound to its top level.
module uart_rb_checker #(
  parameter int RX_DEPTH = uart_rb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = uart_rb_pkg::TX_DEPTH_DEF,
  localparam int RX_LW   = $clog2(RX_DEPTH + 1),
  localparam int TX_LW   = $clog2(TX_DEPTH + 1)
) (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [2:0]       rsp_kind,
  input logic [7:0]       rsp_byte_out,
  input logic             rsp_ok,
  input logic             rsp_last,
  input logic             rsp_tx_irq_enable,
  input logic [RX_LW-1:0] rsp_rx_level,
  input logic [TX_LW-1:0] rsp_tx_level
);
  import uart_rb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_kind, rsp_byte_out, rsp_ok,
      rsp_last, rsp_tx_irq_enable, rsp_rx_level, rsp_tx_level}))
    else $error("result changed while stalled");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_IDLE |->
      rsp_tx_level == '0 && !rsp_tx_irq_enable && rsp_last)
    else $error("idle result with bytes queued or interrupt still enabled");

  a_wack_irq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_WACK |-> rsp_tx_irq_enable && rsp_last)
    else $error("write acknowledge without transmit interrupt enable");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_RXST && !rsp_ok |-> rsp_rx_level == RX_LW'(RX_DEPTH))
    else $error("received byte dropped while receive ring had room");

  a_levels: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_rx_level <= RX_LW'(RX_DEPTH) && rsp_tx_level <= TX_LW'(TX_DEPTH))
    else $error("ring level beyond depth");

endmodule

bind uart_ring_buffers_crlf uart_rb_checker #(
  .RX_DEPTH (RX_DEPTH),
  .TX_DEPTH (TX_DEPTH)
) u_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_kind          (rsp.kind),
  .rsp_byte_out      (rsp.byte_out),
  .rsp_ok            (rsp.ok),
  .rsp_last          (rsp.last),
  .rsp_tx_irq_enable (rsp.tx_irq_enable),
  .rsp_rx_level      (rsp.rx_level),
  .rsp_tx_level      (rsp.tx_level)
);
